### rtl/fixed_cell_free_list_allocator_top_assert.svh
// Assertion macros for the free-list allocator. Each macro expects clk and
// rst_n to be visible in the module that uses it.
`ifndef FIXED_CELL_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_CELL_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCFL_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCFL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fcfl_pkg.sv
package fcfl_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int ELEM_W    = 13;
    localparam int BLK_W     = 9;
    localparam int OFFS_W    = 22;
    localparam int STAT_W    = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADFREE = 2'd2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ELEM_SIZE   = 1'b0;
    localparam logic REG_BLOCK_CELLS = 1'b1;

    localparam logic [ELEM_W-1:0] ELEM_SIZE_RST   = 13'd8;
    localparam logic [BLK_W-1:0]  BLOCK_CELLS_RST = 9'd16;

    typedef struct packed {
        logic [ELEM_W-1:0] elem_size;
        logic [BLK_W-1:0]  block_cells;
    } cfg_t;

    typedef struct packed {
        logic [CELL_W-1:0] grant_idx;
        logic [STAT_W-1:0] status;
        logic              grew;
        logic [CNT_W-1:0]  live;
        logic [CNT_W-1:0]  free;
        logic [CNT_W-1:0]  blocks;
    } alloc_res_t;

endpackage

### rtl/fcfl_ram.sv
module fcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/fcfl_cfg.sv
module fcfl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [fcfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [fcfl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output fcfl_pkg::cfg_t                cfg
);

    import fcfl_pkg::*;

    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic              wr_en;
    logic              reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        elem_next = elem_reg;
        blk_next  = blk_reg;
        prdata    = '0;
        unique case (reg_idx)
            REG_ELEM_SIZE:
            begin
                prdata = {{(PDATA_W-ELEM_W){1'b0}}, elem_reg};
                if (wr_en)
                begin
                    elem_next = pwdata[ELEM_W-1:0];
                end
            end
            REG_BLOCK_CELLS:
            begin
                prdata = {{(PDATA_W-BLK_W){1'b0}}, blk_reg};
                if (wr_en)
                begin
                    blk_next = pwdata[BLK_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg <= ELEM_SIZE_RST;
            blk_reg  <= BLOCK_CELLS_RST;
        end
        else
        begin
            elem_reg <= elem_next;
            blk_reg  <= blk_next;
        end
    end

    assign pready          = 1'b1;
    assign cfg.elem_size   = elem_reg;
    assign cfg.block_cells = blk_reg;

endmodule

### rtl/fcfl_alloc.sv
module fcfl_alloc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcfl_pkg::cfg_t              cfg,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        operation,
    input  logic [fcfl_pkg::CELL_W-1:0] cell_index,
    output logic                        res_valid,
    input  logic                        res_take,
    output fcfl_pkg::alloc_res_t        res
);

    import fcfl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic             state_reg, state_next;
    logic             pop_reg, pop_next;
    logic [CELL_W-1:0] head_reg, head_next;
    logic             nonempty_reg, nonempty_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] opened_reg, opened_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] blocks_reg, blocks_next;
    alloc_res_t       res_reg, res_next;

    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic [CELL_W-1:0] link_rdata;
    logic [BLK_W-1:0]  bc;
    logic [CNT_W:0]    grow_end;
    logic [CNT_W-1:0]  free_dec;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_BUSY);
    assign res       = res_reg;

    // A block size of zero behaves as one.
    assign bc       = (cfg.block_cells == '0) ? BLK_W'(1) : cfg.block_cells;
    assign grow_end = {1'b0, opened_reg} + (CNT_W+1)'(bc);
    assign free_dec = free_reg - CNT_W'(1);

    // Free deallocates write the old head into the link of the freed cell;
    // allocates from the list read the link of the current head.
    fcfl_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_link (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cell_index),
        .wdata (head_reg),
        .re    (mem_re),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        pop_next      = pop_reg;
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        fresh_next    = fresh_reg;
        opened_next   = opened_reg;
        live_next     = live_reg;
        free_next     = free_reg;
        blocks_next   = blocks_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next      = S_BUSY;
                    pop_next        = 1'b0;
                    res_next.grew   = 1'b0;
                    res_next.status = STAT_OK;
                    if (operation == OP_FREE)
                    begin
                        res_next.grant_idx = cell_index;
                        if (live_reg == '0 || {1'b0, cell_index} >= CNT_W'(MAX_CELLS))
                        begin
                            res_next.status = STAT_BADFREE;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            head_next     = cell_index;
                            nonempty_next = 1'b1;
                            live_next     = live_reg - CNT_W'(1);
                            free_next     = free_reg + CNT_W'(1);
                        end
                    end
                    else if (nonempty_reg)
                    begin
                        // The new head arrives from the link memory next cycle.
                        mem_re             = 1'b1;
                        pop_next           = 1'b1;
                        res_next.grant_idx = head_reg;
                        live_next          = live_reg + CNT_W'(1);
                        free_next          = free_dec;
                        nonempty_next      = free_dec > (opened_reg - fresh_reg);
                    end
                    else if (fresh_reg < opened_reg)
                    begin
                        res_next.grant_idx = fresh_reg[CELL_W-1:0];
                        fresh_next         = fresh_reg + CNT_W'(1);
                        live_next          = live_reg + CNT_W'(1);
                        free_next          = free_dec;
                    end
                    else if (grow_end > (CNT_W+1)'(MAX_CELLS))
                    begin
                        res_next.grant_idx = '0;
                        res_next.status    = STAT_OOM;
                    end
                    else
                    begin
                        res_next.grant_idx = opened_reg[CELL_W-1:0];
                        res_next.grew      = 1'b1;
                        fresh_next         = opened_reg + CNT_W'(1);
                        opened_next        = grow_end[CNT_W-1:0];
                        blocks_next        = blocks_reg + CNT_W'(1);
                        free_next          = free_reg + CNT_W'(bc) - CNT_W'(1);
                        live_next          = live_reg + CNT_W'(1);
                    end
                    res_next.live   = live_next;
                    res_next.free   = free_next;
                    res_next.blocks = blocks_next;
                end
            end
            S_BUSY:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                    if (pop_reg)
                    begin
                        head_next = link_rdata;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pop_reg      <= 1'b0;
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            fresh_reg    <= '0;
            opened_reg   <= '0;
            live_reg     <= '0;
            free_reg     <= '0;
            blocks_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pop_reg      <= pop_next;
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            fresh_reg    <= fresh_next;
            opened_reg   <= opened_next;
            live_reg     <= live_next;
            free_reg     <= free_next;
            blocks_reg   <= blocks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### rtl/fixed_cell_free_list_allocator_top.sv
// Fixed-size cell allocator. An allocate transfer (operation 0) pops the
// head of a LIFO list of returned cells; when that list is empty it hands
// out the next untouched cell of the newest block, and opens a new block of
// block_cells cells when the newest one is used up. A deallocate transfer
// (operation 1) pushes cell_index onto the list. Every request transfer
// yields exactly one result transfer carrying the cell, its byte offset
// (cell times elem_size, modulo 2^22), a status (ok, out of memory, or a
// rejected deallocate) and the live, free and block counts after the step.
// The list links live in a 1024-entry memory with a registered read port,
// which needs no clearing after reset. The request transfer issues the
// link read or write, and the busy state that follows collects the new
// list head and moves the result into the output register when that is
// free; no new request is accepted before then. The output register lets
// a new request be accepted while the previous result still waits to be
// taken. The user must write the configuration registers (elem_size at
// byte address 0, block_cells at 4) through the APB port only while no
// request is in flight; the block itself does not enforce this.
module fixed_cell_free_list_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          operation,
    input  logic [fcfl_pkg::CELL_W-1:0]   cell_index,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [fcfl_pkg::CELL_W-1:0]   granted_cell,
    output logic [fcfl_pkg::OFFS_W-1:0]   byte_offset,
    output logic [fcfl_pkg::STAT_W-1:0]   status,
    output logic                          grew,
    output logic [fcfl_pkg::CNT_W-1:0]    live_count,
    output logic [fcfl_pkg::CNT_W-1:0]    free_count,
    output logic [fcfl_pkg::CNT_W-1:0]    blocks_used,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [fcfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [fcfl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import fcfl_pkg::*;

    cfg_t       cfg;
    alloc_res_t res;
    logic       res_valid;
    logic       out_take;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic [CELL_W-1:0]         cell_reg;
    logic [OFFS_W-1:0]         offs_reg;
    logic [STAT_W-1:0]         status_reg;
    logic                      grew_reg;
    logic [CNT_W-1:0]          live_reg;
    logic [CNT_W-1:0]          free_reg;
    logic [CNT_W-1:0]          blocks_reg;
    logic [CELL_W+ELEM_W-1:0]  product;

    fcfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcfl_alloc u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .cell_index (cell_index),
        .res_valid  (res_valid),
        .res_take   (out_take),
        .res        (res)
    );

    // The output register is free when it is empty or its result is being
    // taken in this cycle.
    assign out_take = !rsp_valid_reg || !rsp_stall;

    // The offset multiply works on the registered result of the allocator
    // and lands directly in the output register.
    assign product = CELL_W'(res.grant_idx) * cfg.elem_size;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_take)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_take)
        begin
            cell_reg   <= res.grant_idx;
            offs_reg   <= product[OFFS_W-1:0];
            status_reg <= res.status;
            grew_reg   <= res.grew;
            live_reg   <= res.live;
            free_reg   <= res.free;
            blocks_reg <= res.blocks;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted_cell = cell_reg;
    assign byte_offset  = offs_reg;
    assign status       = status_reg;
    assign grew         = grew_reg;
    assign live_count   = live_reg;
    assign free_count   = free_reg;
    assign blocks_used  = blocks_reg;

`include "fixed_cell_free_list_allocator_top_assert.svh"

    // A request occupies the allocator for at least the next cycle.
    `FCFL_CHECK_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request accepted back to back")

    // Only a successful allocate can open a block.
    `FCFL_CHECK(a_grew_ok, rsp_valid && grew, status == STAT_OK, "grew set on a failed request")

    // An out-of-memory result carries no cell.
    `FCFL_CHECK(a_oom_zero, rsp_valid && status == STAT_OOM, granted_cell == '0 && byte_offset == '0 && !grew, "out of memory result carries a cell")

endmodule

### bench/fixed_cell_free_list_allocator_top_tb.sv
module fixed_cell_free_list_allocator_top_tb;

    import fcfl_pkg::*;

    // The bench keeps two copies of the pool model. The checking copy
    // advances on every request transfer that the block accepts. The planning
    // copy advances while stimulus is generated, so that the generator knows
    // which cells are live and can free them back in a sensible order.
    localparam int POOL_CHECK = 0;
    localparam int POOL_PLAN  = 1;

    // Cycles to wait after the last result before the configuration is
    // touched or the run ends.
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              op;
        logic [CELL_W-1:0] idx;
    } pool_request_t;

    typedef struct packed {
        logic [CELL_W-1:0] slot;
        logic [OFFS_W-1:0] offset;
        logic [STAT_W-1:0] status;
        logic              grew;
        logic [CNT_W-1:0]  live;
        logic [CNT_W-1:0]  free_cnt;
        logic [CNT_W-1:0]  blocks;
    } cell_grant_t;

    // Patterns on which the result side stalls, picked at random by the
    // result monitor.
    typedef enum int {
        DRAIN_FREELY,
        STALL_SOMETIMES,
        STALL_MOSTLY,
        STALL_PERIODIC
    } stall_mode_e;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    logic                operation   = OP_ALLOC;
    logic [CELL_W-1:0]   cell_index  = '0;
    logic                rsp_valid;
    logic                rsp_stall   = 1'b0;
    logic [CELL_W-1:0]   granted_cell;
    logic [OFFS_W-1:0]   byte_offset;
    logic [STAT_W-1:0]   status;
    logic                grew;
    logic [CNT_W-1:0]    live_count;
    logic [CNT_W-1:0]    free_count;
    logic [CNT_W-1:0]    blocks_used;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Pool state, one set per model copy.
    logic [CELL_W-1:0]   link_mem [2][MAX_CELLS];
    logic [CELL_W-1:0]   pool_head [2];
    bit                  pool_listed [2];
    int unsigned         pool_fresh [2];
    int unsigned         pool_opened [2];
    int unsigned         pool_live [2];
    int unsigned         pool_free [2];
    int unsigned         pool_blocks [2];
    logic [ELEM_W-1:0]   cfg_elem [2];
    logic [BLK_W-1:0]    cfg_blk [2];

    pool_request_t       pending_requests [$];
    cell_grant_t         expected_grants [$];
    logic [CELL_W-1:0]   plan_live [$];

    int unsigned         queued_total   = 0;
    int unsigned         accepted_total = 0;
    int unsigned         results_seen   = 0;
    int unsigned         mismatches     = 0;
    int unsigned         burst_left     = 0;
    int unsigned         gap_left       = 0;
    int unsigned         bursts_started = 0;
    bit                  drain_hold     = 1'b0;
    int unsigned         monitor_cycles = 0;
    stall_mode_e         stall_mode     = DRAIN_FREELY;
    int unsigned         quiet_cycles   = 0;

    fixed_cell_free_list_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .cell_index   (cell_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted_cell (granted_cell),
        .byte_offset  (byte_offset),
        .status       (status),
        .grew         (grew),
        .live_count   (live_count),
        .free_count   (free_count),
        .blocks_used  (blocks_used),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    // Advances one copy of the pool by one request and returns the result
    // that the block must produce for it. A deallocate pushes the named cell
    // onto the LIFO list without checking it, unless no cell is live. An
    // allocate pops the list, else takes the next untouched cell of the
    // newest block, else opens a new block if a whole one still fits.
    function automatic cell_grant_t pool_step(input int p, input logic op,
                                              input logic [CELL_W-1:0] idx);
        cell_grant_t       g;
        logic [CELL_W-1:0] slot;
        int unsigned       span;
        g = '0;
        slot = idx;
        g.status = STAT_OK;
        if (op == OP_FREE) begin
            if (pool_live[p] == 0) begin
                g.status = STAT_BADFREE;
            end
            else begin
                link_mem[p][idx] = pool_head[p];
                pool_head[p] = idx;
                pool_listed[p] = 1'b1;
                pool_live[p]--;
                pool_free[p]++;
            end
        end
        else if (pool_listed[p]) begin
            slot = pool_head[p];
            pool_head[p] = link_mem[p][slot];
            pool_live[p]++;
            pool_free[p]--;
            // The list holds whatever free cells are not untouched ones.
            pool_listed[p] = pool_free[p] > (pool_opened[p] - pool_fresh[p]);
        end
        else if (pool_fresh[p] < pool_opened[p]) begin
            slot = CELL_W'(pool_fresh[p]);
            pool_fresh[p]++;
            pool_live[p]++;
            pool_free[p]--;
        end
        else begin
            // A block size of zero behaves as a size of one.
            span = (cfg_blk[p] == '0) ? 1 : int'(cfg_blk[p]);
            if (pool_opened[p] + span > MAX_CELLS) begin
                g.status = STAT_OOM;
                slot = '0;
            end
            else begin
                slot = CELL_W'(pool_opened[p]);
                pool_fresh[p] = pool_opened[p] + 1;
                pool_opened[p] = pool_opened[p] + span;
                pool_blocks[p]++;
                pool_free[p] = pool_free[p] + span - 1;
                pool_live[p]++;
                g.grew = 1'b1;
            end
        end
        g.slot = slot;
        // The offset wraps at the width of the output.
        g.offset = OFFS_W'(32'(slot) * 32'(cfg_elem[p]));
        g.live = CNT_W'(pool_live[p]);
        g.free_cnt = CNT_W'(pool_free[p]);
        g.blocks = CNT_W'(pool_blocks[p]);
        return g;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Appends one request to the stimulus and follows it in the planning
    // copy, keeping the list of cells that the plan considers live.
    task automatic queue_request(input logic op, input logic [CELL_W-1:0] idx);
        cell_grant_t plan;
        int          hits [$];
        plan = pool_step(POOL_PLAN, op, idx);
        if (op == OP_ALLOC && plan.status == STAT_OK) begin
            plan_live.push_back(plan.slot);
        end
        else if (op == OP_FREE && plan.status == STAT_OK) begin
            hits = plan_live.find_first_index(item) with (item == idx);
            if (hits.size() != 0) begin
                plan_live.delete(hits[0]);
            end
        end
        pending_requests.push_back('{op: op, idx: idx});
        queued_total++;
    endtask

    // Mostly well-formed traffic: allocations, and frees of cells that are
    // live. A few frees name any cell at all, which gives double frees,
    // frees of cells never handed out and frees with nothing live.
    task automatic queue_mixed_requests(input int count, input int alloc_pct);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = int'($urandom_range(0, 99));
            if (roll < alloc_pct) begin
                queue_request(OP_ALLOC, CELL_W'($urandom_range(0, MAX_CELLS - 1)));
            end
            else if (roll < 96 && plan_live.size() != 0) begin
                queue_request(OP_FREE, plan_live[$urandom_range(0, plan_live.size() - 1)]);
            end
            else begin
                queue_request(OP_FREE, CELL_W'($urandom_range(0, MAX_CELLS - 1)));
            end
        end
    endtask

    // Waits until every queued request has been accepted and every result
    // has come back, then lets the block settle.
    task automatic wait_idle();
        while (accepted_total != queued_total || expected_grants.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register through the APB port and reads it back. The
    // checking copy takes the new value at the edge where the write lands.
    task automatic set_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_sel == REG_ELEM_SIZE) begin
            cfg_elem[POOL_CHECK] = ELEM_W'(value);
            want = PDATA_W'(cfg_elem[POOL_CHECK]);
        end
        else begin
            cfg_blk[POOL_CHECK] = BLK_W'(value);
            want = PDATA_W'(cfg_blk[POOL_CHECK]);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want) begin
            report_mismatch($sformatf("register at %0d reads %0d, expected %0d",
                                      paddr, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Starts a phase of random traffic under a new configuration. The block
    // is idle whenever the registers are written.
    task automatic run_phase(input logic [ELEM_W-1:0] elem, input logic [BLK_W-1:0] blk,
                             input int count, input int alloc_pct);
        wait_idle();
        set_register(REG_ELEM_SIZE, PDATA_W'(elem));
        set_register(REG_BLOCK_CELLS, PDATA_W'(blk));
        cfg_elem[POOL_PLAN] = elem;
        cfg_blk[POOL_PLAN] = blk;
        queue_mixed_requests(count, alloc_pct);
    endtask

    // Request driver. It sends transfers from the pending queue in bursts of
    // random length with random gaps. After some bursts it holds off until
    // every outstanding result has returned. A stalled transfer is held
    // unchanged, and the valid is decided without looking at the stall.
    always @(posedge clk) begin
        pool_request_t req_next;
        bit            send;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end
        else begin
            // The prediction for an accepted request is made here, at the
            // edge of the transfer.
            if (req_valid && !req_stall) begin
                expected_grants.push_back(pool_step(POOL_CHECK, operation, cell_index));
                accepted_total++;
            end
            if (!(req_valid && req_stall)) begin
                send = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end
                else if (drain_hold) begin
                    drain_hold = (expected_grants.size() != 0);
                end
                else if (pending_requests.size() != 0) begin
                    req_next = pending_requests.pop_front();
                    send = 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        bursts_started++;
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        drain_hold = (bursts_started == 3) || ($urandom_range(0, 11) == 0);
                    end
                    operation  <= req_next.op;
                    cell_index <= req_next.idx;
                end
                req_valid <= send;
            end
        end
    end

    // Result monitor. Each result transfer is compared field by field with
    // the oldest prediction. The stall follows its own randomly picked
    // pattern, which includes stretches with no stall at all.
    always @(posedge clk) begin
        cell_grant_t want;
        bit          stall_next;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                results_seen++;
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected, cell %0d",
                                              results_seen, granted_cell));
                end
                else begin
                    want = expected_grants.pop_front();
                    if (granted_cell !== want.slot)
                        report_mismatch($sformatf("result %0d granted_cell %0d, expected %0d",
                                                  results_seen, granted_cell, want.slot));
                    if (byte_offset !== want.offset)
                        report_mismatch($sformatf("result %0d byte_offset %0d, expected %0d",
                                                  results_seen, byte_offset, want.offset));
                    if (status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  results_seen, status, want.status));
                    if (grew !== want.grew)
                        report_mismatch($sformatf("result %0d grew %0d, expected %0d",
                                                  results_seen, grew, want.grew));
                    if (live_count !== want.live)
                        report_mismatch($sformatf("result %0d live_count %0d, expected %0d",
                                                  results_seen, live_count, want.live));
                    if (free_count !== want.free_cnt)
                        report_mismatch($sformatf("result %0d free_count %0d, expected %0d",
                                                  results_seen, free_count, want.free_cnt));
                    if (blocks_used !== want.blocks)
                        report_mismatch($sformatf("result %0d blocks_used %0d, expected %0d",
                                                  results_seen, blocks_used, want.blocks));
                end
            end
            if (monitor_cycles % 64 == 0) begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
            end
            monitor_cycles++;
            case (stall_mode)
                DRAIN_FREELY:    stall_next = 1'b0;
                STALL_SOMETIMES: stall_next = ($urandom_range(0, 3) == 0);
                STALL_MOSTLY:    stall_next = ($urandom_range(0, 3) != 0);
                default:         stall_next = (monitor_cycles % 5) < 2;
            endcase
            rsp_stall <= stall_next;
        end
    end

    // The watchdog ends the run when no transfer of any kind happens for a
    // long time, which also catches a result that never arrives.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < MAX_CELLS; i++) begin
                link_mem[p][i] = '0;
            end
            pool_head[p] = '0;
            pool_listed[p] = 1'b0;
            pool_fresh[p] = 0;
            pool_opened[p] = 0;
            pool_live[p] = 0;
            pool_free[p] = 0;
            pool_blocks[p] = 0;
            cfg_elem[p] = ELEM_SIZE_RST;
            cfg_blk[p] = BLOCK_CELLS_RST;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset configuration. A free with nothing
        // live is rejected, and allocations then open the first block.
        queue_request(OP_FREE, CELL_W'(MAX_CELLS - 1));
        queue_request(OP_ALLOC, '0);
        queue_request(OP_ALLOC, '1);
        queue_request(OP_ALLOC, CELL_W'(MAX_CELLS / 2));
        // Returned cells come back in LIFO order.
        queue_request(OP_FREE, CELL_W'(1));
        queue_request(OP_FREE, CELL_W'(2));
        queue_request(OP_ALLOC, '0);
        queue_request(OP_ALLOC, '0);
        // Frees are not checked: a cell never handed out, then a double free.
        queue_request(OP_FREE, '1);
        queue_request(OP_FREE, '0);
        queue_request(OP_FREE, '0);
        // Nothing is live any more, so this free is rejected.
        queue_request(OP_FREE, CELL_W'(5));
        queue_request(OP_ALLOC, '0);
        queue_request(OP_ALLOC, '0);
        queue_request(OP_ALLOC, '0);
        // Use up the untouched cells of the first block.
        for (int n = 0; n < 13; n++) begin
            queue_request(OP_ALLOC, CELL_W'($urandom_range(0, MAX_CELLS - 1)));
        end

        // Random phases. Blocks of one cell, of zero (acting as one), the
        // largest sizes and odd sizes; element sizes at both ends of the
        // register, where the offset wraps. The pool fills up towards the
        // end, so that allocations run out of memory and recycling at a full
        // pool is covered.
        run_phase(ELEM_W'(4096), BLK_W'(1), 250, 60);
        run_phase('1, '0, 200, 55);
        run_phase(ELEM_W'(8), BLK_W'(256), 250, 55);
        run_phase('0, BLK_W'(3), 200, 50);
        run_phase(ELEM_W'($urandom_range(8, 4096)), BLK_W'($urandom_range(2, 40)), 300, 55);
        run_phase(ELEM_W'($urandom_range(8, 4096)), '1, 150, 60);
        run_phase(ELEM_W'(4096), BLK_W'(256), 300, 90);
        run_phase(ELEM_W'($urandom_range(8, 4096)), BLK_W'($urandom_range(1, 256)), 300, 50);

        wait_idle();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end
        else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
